/* rtl/core/rrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared constants and types for the RSSI rank sorter.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = 5;
    localparam int STR_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int TALLY_W     = 6;
    localparam int CHANNELS    = 13;
    localparam int FIRST_CHAN  = 1;
    localparam int CIDX_W      = $clog2(CHANNELS);

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_TALLY = 1'b1;

    typedef struct packed {
        logic signed [STR_W-1:0] strength;
        logic [POS_W-1:0]        number;
    } rrs_entry_t;

    typedef struct packed {
        logic       insert;
        logic       shift;
        rrs_entry_t new_entry;
    } rrs_cell_ctrl_t;

endpackage

/* rtl/core/rrs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_cell
// One slot of the ranking chain: keeps, takes the new beat or takes a neighbour.
// ----------------------------------------------------------------------------
module rrs_cell (
    input  logic                   clk,
    input  rrs_pkg::rrs_cell_ctrl_t ctrl,
    input  logic                   occupied,
    input  logic                   prev_keeps,
    input  rrs_pkg::rrs_entry_t    prev_entry,
    input  rrs_pkg::rrs_entry_t    next_entry,
    output rrs_pkg::rrs_entry_t    entry,
    output logic                   keeps
);
    import rrs_pkg::*;

    rrs_entry_t entry_reg;
    rrs_entry_t entry_next;

    // strict-less insertion: equal strengths stay ahead of the newcomer
    assign keeps = occupied && (entry_reg.strength >= ctrl.new_entry.strength);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert && !keeps)
        begin
            entry_next = prev_keeps ? ctrl.new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/rssi_rank_sorter_with_channel_histogram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_rank_sorter_with_channel_histogram
// Stable descending rank of scanned networks plus a channel 1..13 histogram.
// ----------------------------------------------------------------------------
// A non-final beat is absorbed while busy stays low, so one beat per cycle is
//   taken while start is held high. A final beat starts a run of N ranked lines
//   and then 13 channel tallies (N kept networks); busy holds through the run,
//   whose ranks come from the one-slot-per-cycle drain of the cell chain.
// Results cannot be stalled: each shows for one cycle with result_strobe.
// Reset (rst_n low, asynchronous) clears count, histogram, state and strobe.
// ----------------------------------------------------------------------------
module rssi_rank_sorter_with_channel_histogram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        has_entry,
    input  logic signed [7:0]           strength,
    input  logic [7:0]                  chan_num,
    input  logic                        final_item,
    output logic                        result_strobe,
    output logic                        kind,
    output logic [4:0]                  position,
    output logic [4:0]                  net_number,
    output logic signed [7:0]           strength_out,
    output logic [5:0]                  tally,
    output logic                        run_end
);
    import rrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RANK  = 3'b010,
        S_TALLY = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       kept_reg, kept_next;
    logic [CNT_W-1:0]       rank_idx_reg, rank_idx_next;
    logic [CIDX_W-1:0]      chan_idx_reg, chan_idx_next;
    logic [TALLY_W-1:0]     hist_reg [CHANNELS];

    logic                   strobe_reg, strobe_next;
    logic                   kind_reg, kind_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       num_reg, num_next;
    logic signed [STR_W-1:0] str_reg, str_next;
    logic [TALLY_W-1:0]     tally_reg, tally_next;
    logic                   end_reg, end_next;

    logic                   accept;
    logic                   take;
    logic                   chan_ok;
    logic [CHAN_W-1:0]      chan_off;
    logic                   hist_clear;

    rrs_cell_ctrl_t         cell_ctrl;
    rrs_entry_t             cell_entry [MAX_ENTRIES];
    logic                   cell_keeps [MAX_ENTRIES];

    // handshake: a beat lands when start is high and the run is not draining
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign take   = accept && has_entry && (kept_reg < CNT_W'(MAX_ENTRIES));

    // channels outside 1..13 are ranked but not counted
    assign chan_off = chan_num - CHAN_W'(FIRST_CHAN);
    assign chan_ok  = (chan_num >= CHAN_W'(FIRST_CHAN))
                   && (chan_off < CHAN_W'(CHANNELS));

    // control broadcast along the chain
    always_comb
    begin
        cell_ctrl.insert             = take;
        cell_ctrl.shift              = (state_reg == S_RANK);
        cell_ctrl.new_entry.strength = strength;
        cell_ctrl.new_entry.number   = kept_reg[POS_W-1:0];
    end

    // the ranking chain; slot 0 is the strongest and also the drain point
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic       occ;
        logic       prev_keeps;
        rrs_entry_t prev_entry;
        rrs_entry_t next_entry;

        assign occ = (CNT_W'(i) < kept_reg);

        if (i == 0)
        begin : g_head
            assign prev_keeps = 1'b1;
            assign prev_entry = cell_ctrl.new_entry;
        end
        else
        begin : g_body
            assign prev_keeps = cell_keeps[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_link
            assign next_entry = cell_entry[i+1];
        end

        rrs_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .occupied   (occ),
            .prev_keeps (prev_keeps),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .keeps      (cell_keeps[i])
        );
    end

    // run sequencer: ranked entries first, then the 13 tallies
    always_comb
    begin
        state_next    = state_reg;
        kept_next     = kept_reg;
        rank_idx_next = rank_idx_reg;
        chan_idx_next = chan_idx_reg;
        hist_clear    = 1'b0;

        strobe_next = 1'b0;
        kind_next   = KIND_ENTRY;
        pos_next    = '0;
        num_next    = '0;
        str_next    = '0;
        tally_next  = '0;
        end_next    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (accept && final_item)
                begin
                    rank_idx_next = '0;
                    chan_idx_next = '0;
                    if (take || (kept_reg != '0))
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_TALLY;
                    end
                end
            end
            S_RANK:
            begin
                strobe_next   = 1'b1;
                kind_next     = KIND_ENTRY;
                pos_next      = rank_idx_reg[POS_W-1:0];
                num_next      = cell_entry[0].number;
                str_next      = cell_entry[0].strength;
                rank_idx_next = rank_idx_reg + CNT_W'(1);
                if (rank_idx_reg == kept_reg - CNT_W'(1))
                begin
                    state_next = S_TALLY;
                    kept_next  = '0;
                end
            end
            S_TALLY:
            begin
                strobe_next   = 1'b1;
                kind_next     = KIND_TALLY;
                pos_next      = POS_W'(chan_idx_reg) + POS_W'(FIRST_CHAN);
                tally_next    = hist_reg[chan_idx_reg];
                chan_idx_next = chan_idx_reg + CIDX_W'(1);
                if (chan_idx_reg == CIDX_W'(CHANNELS - 1))
                begin
                    end_next   = 1'b1;
                    hist_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kept_reg     <= '0;
            rank_idx_reg <= '0;
            chan_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kept_reg     <= kept_next;
            rank_idx_reg <= rank_idx_next;
            chan_idx_reg <= chan_idx_next;
            strobe_reg   <= strobe_next;
        end
    end

    // histogram bins; cleared together once the last tally has gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (hist_clear)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (take && chan_ok)
        begin
            hist_reg[chan_off[CIDX_W-1:0]] <= hist_reg[chan_off[CIDX_W-1:0]]
                                            + TALLY_W'(1);
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        pos_reg   <= pos_next;
        num_reg   <= num_next;
        str_reg   <= str_next;
        tally_reg <= tally_next;
        end_reg   <= end_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign position      = pos_reg;
    assign net_number    = num_reg;
    assign strength_out  = str_reg;
    assign tally         = tally_reg;
    assign run_end       = end_reg;

`ifndef NO_ASSERTIONS
    a_entry_from_rank : assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && kind == KIND_ENTRY) |-> $past(state_reg == S_RANK))
        else $error("ranked beat outside the rank drain");

    a_run_end_last_tally : assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && run_end) |->
            (kind == KIND_TALLY && position == POS_W'(FIRST_CHAN + CHANNELS - 1)))
        else $error("run end not on the last channel tally");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= CNT_W'(MAX_ENTRIES))
        else $error("kept count beyond capacity");

    a_idle_after_end : assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && run_end) |-> (state_reg == S_IDLE && kept_reg == '0))
        else $error("scan not closed after its last beat");
`endif

endmodule

/* test/rssi_rank_sorter_with_channel_histogram_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_rank_sorter_with_channel_histogram_tb
// Drives scans of networks into the rank sorter and predicts every output
// line: the strength ranking (stable on ties), the drop past a full list and
// the per-channel tally. Each strobed line is compared with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module rssi_rank_sorter_with_channel_histogram_tb;

    import rrs_pkg::*;

    // Cycles with neither an accepted beat nor a strobed line before giving up.
    // The longest legal stretch is a rest gap or the settle wait at the end, as each
    // strobed line restarts the count, so this is many times over.
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS = 20;

    // One output line of a scan run, as the block presents it
    typedef struct packed {
        logic                    kind;
        logic [4:0]              position;
        logic [4:0]              net_number;
        logic signed [7:0]       strength_out;
        logic [5:0]              tally;
        logic                    run_end;
    } scan_line_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              has_entry = 1'b0;
    logic signed [7:0] strength = '0;
    logic [7:0]        chan_num = '0;
    logic              final_item = 1'b0;
    logic              result_strobe;
    logic              kind;
    logic [4:0]        position;
    logic [4:0]        net_number;
    logic signed [7:0] strength_out;
    logic [5:0]        tally;
    logic              run_end;

    // Predictor state: ranked list, kept count and channel histogram
    rrs_entry_t ranked [MAX_ENTRIES];
    int         kept_nets;
    int         chan_hits [CHANNELS];

    scan_line_t due_lines [$];

    int  fault_count;
    int  beats_sent;
    int  net_beats;
    int  lines_checked;
    int  scans_closed;
    int  nets_dropped;
    int  stall_cycles;
    bit  gaps_on;

    rssi_rank_sorter_with_channel_histogram dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .has_entry     (has_entry),
        .strength      (strength),
        .chan_num      (chan_num),
        .final_item    (final_item),
        .result_strobe (result_strobe),
        .kind          (kind),
        .position      (position),
        .net_number    (net_number),
        .strength_out  (strength_out),
        .tally         (tally),
        .run_end       (run_end)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: takes one accepted beat, updates the ranking and histogram,
    // and queues the lines of the run when the beat closes a scan.
    // ------------------------------------------------------------------------
    function automatic void rank_scan_item(bit has, logic signed [7:0] str,
                                           logic [7:0] ch, bit fin);
        int         slot;
        scan_line_t line;
        if (has)
        begin
            if (kept_nets >= MAX_ENTRIES)
            begin
                // full list: no number, no rank, no tally
                nets_dropped++;
            end
            else
            begin
                // strict-less search keeps earlier arrivals ahead on ties
                slot = 0;
                while (slot < kept_nets && ranked[slot].strength >= str)
                    slot++;
                for (int j = kept_nets; j > slot; j--)
                    ranked[j] = ranked[j-1];
                ranked[slot].strength = str;
                ranked[slot].number   = POS_W'(kept_nets);
                // channels outside 1..13 are ranked but not counted
                if (ch >= FIRST_CHAN && ch < FIRST_CHAN + CHANNELS)
                    chan_hits[ch - FIRST_CHAN]++;
                kept_nets++;
            end
        end
        if (fin)
        begin
            for (int i = 0; i < kept_nets; i++)
            begin
                line              = '0;
                line.kind         = KIND_ENTRY;
                line.position     = 5'(i);
                line.net_number   = ranked[i].number;
                line.strength_out = ranked[i].strength;
                due_lines.push_back(line);
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                line          = '0;
                line.kind     = KIND_TALLY;
                line.position = 5'(c + FIRST_CHAN);
                line.tally    = 6'(chan_hits[c]);
                line.run_end  = (c == CHANNELS - 1);
                due_lines.push_back(line);
                chan_hits[c] = 0;
            end
            kept_nets = 0;
            scans_closed++;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %0d, want %0d (line %0d)",
                     what, got, want, lines_checked);
    endtask

    // ------------------------------------------------------------------------
    // Sender side. A beat is presented at the falling edge and taken at the
    // first rising edge with busy low; start is left high so that a
    // following beat can go out back to back.
    // ------------------------------------------------------------------------
    task automatic send_beat(bit has, logic signed [7:0] str, logic [7:0] ch,
                             bit fin);
        @(negedge clk);
        start      <= 1'b1;
        has_entry  <= has;
        strength   <= str;
        chan_num   <= ch;
        final_item <= fin;
        do
            @(posedge clk);
        while (busy);
        rank_scan_item(has, str, ch, fin);
        beats_sent++;
        if (has || fin)
            net_beats++;
    endtask

    task automatic rest(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_rest();
        if (gaps_on && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 15));
    endtask

    task automatic send_net(logic signed [7:0] str, logic [7:0] ch, bit fin);
        send_beat(1'b1, str, ch, fin);
        maybe_rest();
    endtask

    task automatic send_close();
        send_beat(1'b0, 8'($urandom), 8'($urandom), 1'b1);
        maybe_rest();
    endtask

    // mostly near-equal strengths so that ties are common
    function automatic logic signed [7:0] pick_strength();
        case ($urandom_range(0, 2))
            0, 1:    return 8'($urandom_range(0, 5) - 64);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 15));
    endfunction

    // One well-formed scan of the given size, with ignored beats mixed in
    task automatic random_scan(int nets);
        bit fin_carries;
        fin_carries = (nets > 0) && $urandom_range(0, 1);
        for (int n = 0; n < nets; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_beat(1'b0, 8'($urandom), 8'($urandom), 1'b0);
                maybe_rest();
            end
            if (fin_carries && n == nets - 1)
                send_net(pick_strength(), pick_channel(), 1'b1);
            else
                send_net(pick_strength(), pick_channel(), 1'b0);
        end
        if (!fin_carries)
            send_close();
    endtask

    function automatic int pick_scan_size();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(32, 40);
            1, 2, 3,
            4, 5:    return $urandom_range(9, 31);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_items();
        // ignored beats, then a bare close: 13 zero tallies only
        send_beat(1'b0, 8'sd127, 8'd5, 1'b0);
        send_beat(1'b0, -8'sd128, 8'd255, 1'b0);
        send_close();
    endtask

    task automatic test_field_extremes();
        send_net(8'sd127, 8'd1, 1'b0);
        send_net(-8'sd128, 8'd13, 1'b0);
        send_net(8'sd0, 8'd0, 1'b0);
        send_net(-8'sd1, 8'd14, 1'b0);
        send_net(-8'sd128, 8'd255, 1'b0);
        send_net(8'sd127, 8'd7, 1'b0);
        // closing beat brings its own network, ranked before the run
        send_net(8'sd5, 8'd13, 1'b1);
    endtask

    task automatic test_stable_ties();
        send_net(-8'sd70, 8'd6, 1'b0);
        send_net(-8'sd40, 8'd6, 1'b0);
        send_net(-8'sd70, 8'd6, 1'b0);
        send_net(-8'sd90, 8'd12, 1'b0);
        send_net(-8'sd70, 8'd6, 1'b0);
        send_net(-8'sd40, 8'd11, 1'b0);
        send_net(-8'sd70, 8'd2, 1'b0);
        send_close();
    endtask

    task automatic test_full_list();
        // fill past capacity; the overflow beats must leave no trace
        for (int n = 0; n < MAX_ENTRIES + 3; n++)
            send_net(pick_strength(), pick_channel(), 1'b0);
        send_net(8'sd127, 8'd3, 1'b1);
    endtask

    task automatic test_random_scans(int beat_target);
        int goal;
        goal = net_beats + beat_target;
        while (net_beats < goal)
            random_scan(pick_scan_size());
    endtask

    task automatic test_sender_pause();
        random_scan($urandom_range(3, 10));
        // hold off until the whole run has been seen
        @(negedge clk);
        start <= 1'b0;
        while (due_lines.size() != 0)
            @(posedge clk);
        random_scan($urandom_range(1, 6));
    endtask

    task automatic test_back_to_back(int beat_target);
        gaps_on = 1'b0;
        test_random_scans(beat_target);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobe is one line and must match the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        scan_line_t want;
        if (rst_n && result_strobe)
        begin
            if (due_lines.size() == 0)
            begin
                report_mismatch("unexpected line, kind", kind, 0);
            end
            else
            begin
                want = due_lines.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (net_number !== want.net_number)
                    report_mismatch("net_number", net_number, want.net_number);
                if (strength_out !== want.strength_out)
                    report_mismatch("strength_out", strength_out, want.strength_out);
                if (tally !== want.tally)
                    report_mismatch("tally", tally, want.tally);
                if (run_end !== want.run_end)
                    report_mismatch("run_end", run_end, want.run_end);
            end
            lines_checked++;
        end
    end

    // Watchdog: no beat taken and no line shown for too long
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || result_strobe)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d lines outstanding",
                     stall_cycles, due_lines.size());
            $display("rssi_rank_sorter_with_channel_histogram_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        kept_nets = 0;
        for (int c = 0; c < CHANNELS; c++)
            chan_hits[c] = 0;
        gaps_on = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_items();
        test_field_extremes();
        test_stable_ties();
        test_full_list();
        test_random_scans(160);
        test_sender_pause();
        test_random_scans(100);
        test_back_to_back(80);

        @(negedge clk);
        start <= 1'b0;
        while (due_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d beats over %0d scans, %0d lines checked, %0d networks dropped",
                 beats_sent, scans_closed, lines_checked, nets_dropped);
        $display("incl. empty scans, ties, off-band channels, a drained pause, back-to-back");
        if (fault_count == 0)
            $display("rssi_rank_sorter_with_channel_histogram_tb: clean");
        else
            $display("rssi_rank_sorter_with_channel_histogram_tb: errors");
        $finish;
    end

endmodule
